[rtl/core/tmps_pkg.sv]
// ----------------------------------------------------------------------------
// tmps_pkg
// types, constants and helpers shared by the map pixel shader
// ----------------------------------------------------------------------------
package tmps_pkg;

    localparam int NORMAL_W  = 8;
    localparam int SUN_W     = 12;
    localparam int KIND_W    = 2;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int COLOR_W   = 8;
    localparam int LIGHT_W   = 20;
    localparam int PROD_W    = NORMAL_W + SUN_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int PAL_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int PAL_IDX_W = 3;

    localparam logic signed [LIGHT_W-1:0] LIGHT_RESET = -20'sd200000;
    localparam logic signed [LIGHT_W-1:0] LIGHT_MAX   = 20'sd524287;
    localparam logic signed [LIGHT_W-1:0] LIGHT_MIN   = -20'sd524288;
    localparam logic signed [LIGHT_W-1:0] BAND_HIGH   = 20'sd6500;
    localparam logic signed [LIGHT_W-1:0] BAND_LOW    = -20'sd6500;

    localparam logic signed [SUN_W-1:0] SUN_X_RESET = 12'sd1024;

    localparam logic [KIND_W-1:0] KIND_WATER = 2'd0;

    localparam logic [PAL_IDX_W-1:0] PAL_WATER     = 3'd0;
    localparam logic [PAL_IDX_W-1:0] PAL_NIGHT_OFS = 3'd2;
    localparam logic [PAL_IDX_W-1:0] PAL_EDGE      = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUN_X     = 3'd0,
        REG_SUN_Y     = 3'd1,
        REG_SUN_Z     = 3'd2,
        REG_DAY_NIGHT = 3'd3,
        REG_EDGE      = 3'd4,
        REG_PALETTE   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SUN_W-1:0] sun_x;
        logic signed [SUN_W-1:0] sun_y;
        logic signed [SUN_W-1:0] sun_z;
        logic                    day_night_enable;
        logic                    edge_enable;
        logic [PAL_W-1:0]        palette_words;
    } cfg_t;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic [KIND_W-1:0]          land_kind;
        logic                       is_edge;
        logic [COL_W-1:0]           pixel_col;
        logic [ROW_W-1:0]           pixel_row;
        logic                       frame_start;
    } item_t;

    typedef struct packed {
        logic signed [LIGHT_W-1:0] light;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
    } track_t;

    function automatic logic [COLOR_W-1:0] pal_color(
        input logic [PAL_W-1:0]     palette,
        input logic [PAL_IDX_W-1:0] idx
    );
        logic [COLOR_W-1:0] c;
        begin
            case (idx)
                3'd0:    c = palette[7:0];
                3'd1:    c = palette[15:8];
                3'd2:    c = palette[23:16];
                3'd3:    c = palette[31:24];
                3'd4:    c = palette[39:32];
                3'd5:    c = palette[47:40];
                default: c = palette[7:0];
            endcase
            return c;
        end
    endfunction

endpackage

[rtl/core/tmps_in_if.sv]
// ----------------------------------------------------------------------------
// tmps_in_if
// pixel item channel: valid/ready handshake with the shading inputs
// ----------------------------------------------------------------------------
interface tmps_in_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [tmps_pkg::NORMAL_W-1:0]          normal_x;
    logic signed [tmps_pkg::NORMAL_W-1:0]          normal_y;
    logic signed [tmps_pkg::NORMAL_W-1:0]          normal_z;
    logic [tmps_pkg::KIND_W-1:0]                   land_kind;
    logic                                          is_edge;
    logic [tmps_pkg::COL_W-1:0]                    pixel_col;
    logic [tmps_pkg::ROW_W-1:0]                    pixel_row;
    logic                                          frame_start;

    modport source (
        output valid, normal_x, normal_y, normal_z, land_kind, is_edge,
               pixel_col, pixel_row, frame_start,
        input  ready
    );

    modport sink (
        input  valid, normal_x, normal_y, normal_z, land_kind, is_edge,
               pixel_col, pixel_row, frame_start,
        output ready
    );
endinterface

[rtl/core/tmps_out_if.sv]
// ----------------------------------------------------------------------------
// tmps_out_if
// shaded item channel: valid/ready handshake with color and brightest spot
// ----------------------------------------------------------------------------
interface tmps_out_if;
    logic                           valid;
    logic                           ready;
    logic [tmps_pkg::COLOR_W-1:0]   pixel_color;
    logic [tmps_pkg::COL_W-1:0]     brightest_col;
    logic [tmps_pkg::ROW_W-1:0]     brightest_row;

    modport source (
        output valid, pixel_color, brightest_col, brightest_row,
        input  ready
    );

    modport sink (
        input  valid, pixel_color, brightest_col, brightest_row,
        output ready
    );
endinterface

[rtl/core/tmps_cfg.sv]
// ----------------------------------------------------------------------------
// tmps_cfg
// configuration register file: sun vector, mode enables and palette
// ----------------------------------------------------------------------------
module tmps_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tmps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmps_pkg::PAL_W-1:0]         cfg_data,
    output tmps_pkg::cfg_t                     cfg
);

    tmps_pkg::cfg_t cfg_reg;
    tmps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tmps_pkg::REG_SUN_X:     cfg_next.sun_x = cfg_data[tmps_pkg::SUN_W-1:0];
                tmps_pkg::REG_SUN_Y:     cfg_next.sun_y = cfg_data[tmps_pkg::SUN_W-1:0];
                tmps_pkg::REG_SUN_Z:     cfg_next.sun_z = cfg_data[tmps_pkg::SUN_W-1:0];
                tmps_pkg::REG_DAY_NIGHT: cfg_next.day_night_enable = cfg_data[0];
                tmps_pkg::REG_EDGE:      cfg_next.edge_enable = cfg_data[0];
                tmps_pkg::REG_PALETTE:   cfg_next.palette_words = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sun_x            <= tmps_pkg::SUN_X_RESET;
            cfg_reg.sun_y            <= '0;
            cfg_reg.sun_z            <= '0;
            cfg_reg.day_night_enable <= 1'b0;
            cfg_reg.edge_enable      <= 1'b0;
            cfg_reg.palette_words    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/tmps_shade.sv]
// ----------------------------------------------------------------------------
// tmps_shade
// lighting dot product, day/night color pick and brightest-pixel compare
// ----------------------------------------------------------------------------
module tmps_shade (
    input  tmps_pkg::cfg_t                  cfg,
    input  tmps_pkg::item_t                 item,
    input  tmps_pkg::track_t                track,
    output logic [tmps_pkg::COLOR_W-1:0]    color,
    output tmps_pkg::track_t                track_next
);

    logic signed [tmps_pkg::PROD_W-1:0]  prod_x;
    logic signed [tmps_pkg::PROD_W-1:0]  prod_y;
    logic signed [tmps_pkg::PROD_W-1:0]  prod_z;
    logic signed [tmps_pkg::SUM_W-1:0]   sum;
    logic signed [tmps_pkg::LIGHT_W-1:0] light;
    tmps_pkg::track_t                    track_eff;
    logic                                land;
    logic                                night;
    logic                                in_band;
    logic [tmps_pkg::PAL_IDX_W-1:0]      pal_idx;

    assign prod_x = item.normal_x * cfg.sun_x;
    assign prod_y = item.normal_y * cfg.sun_y;
    assign prod_z = item.normal_z * cfg.sun_z;
    assign sum    = tmps_pkg::SUM_W'(prod_x) + tmps_pkg::SUM_W'(prod_y)
                  + tmps_pkg::SUM_W'(prod_z);

    // saturate to the tracking range
    always_comb
    begin
        if (sum > tmps_pkg::SUM_W'(tmps_pkg::LIGHT_MAX))
            light = tmps_pkg::LIGHT_MAX;
        else if (sum < tmps_pkg::SUM_W'(tmps_pkg::LIGHT_MIN))
            light = tmps_pkg::LIGHT_MIN;
        else
            light = sum[tmps_pkg::LIGHT_W-1:0];
    end

    assign land = (item.land_kind != tmps_pkg::KIND_WATER);

    // frame start drops the previous frame's brightest pixel
    always_comb
    begin
        if (item.frame_start)
        begin
            track_eff.light = tmps_pkg::LIGHT_RESET;
            track_eff.col   = '0;
            track_eff.row   = '0;
        end
        else
        begin
            track_eff = track;
        end
    end

    always_comb
    begin
        track_next = track_eff;
        if (land && (light > track_eff.light))
        begin
            track_next.light = light;
            track_next.col   = item.pixel_col;
            track_next.row   = item.pixel_row;
        end
    end

    assign in_band = (light > tmps_pkg::BAND_LOW) && (light < tmps_pkg::BAND_HIGH);

    always_comb
    begin
        night = cfg.day_night_enable && light[tmps_pkg::LIGHT_W-1];
        if (cfg.day_night_enable && in_band)
            night = item.pixel_col[0] ^ item.pixel_row[0];
    end

    always_comb
    begin
        pal_idx = tmps_pkg::PAL_IDX_W'(item.land_kind);
        if (night)
            pal_idx = pal_idx + tmps_pkg::PAL_NIGHT_OFS;
        if (!land)
            pal_idx = tmps_pkg::PAL_WATER;
        else if (cfg.edge_enable && item.is_edge)
            pal_idx = tmps_pkg::PAL_EDGE;
    end

    assign color = tmps_pkg::pal_color(cfg.palette_words, pal_idx);

endmodule

[rtl/core/terminator_map_pixel_shader.sv]
// ----------------------------------------------------------------------------
// terminator_map_pixel_shader
// Shades one map pixel per item and tracks the frame's brightest land pixel.
// An item is taken into an input register, shaded by one pass of logic (three
// 8x12 products, a saturating sum, the palette pick and the brightest compare)
// and lands in a result register; while the output is not stalled, one item is
// accepted every cycle. The brightest-pixel state is updated in that same
// pass, which sets the one-item-per-cycle rate. The input side keeps taking
// items while a result waits, as long as the input register is empty.
// ----------------------------------------------------------------------------
module terminator_map_pixel_shader (
    input  logic                               clk,
    input  logic                               rst_n,
    tmps_in_if.sink                            pixel,
    tmps_out_if.source                         shade,
    input  logic                               cfg_we,
    input  logic [tmps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmps_pkg::PAL_W-1:0]         cfg_data
);

    tmps_pkg::cfg_t                  cfg;
    tmps_pkg::item_t                 item_reg;
    logic                            item_valid_reg;
    tmps_pkg::track_t                track_reg;
    tmps_pkg::track_t                track_next;
    logic [tmps_pkg::COLOR_W-1:0]    color_next;
    logic [tmps_pkg::COLOR_W-1:0]    color_reg;
    logic [tmps_pkg::COL_W-1:0]      bcol_reg;
    logic [tmps_pkg::ROW_W-1:0]      brow_reg;
    logic                            out_valid_reg;
    logic                            out_free;
    logic                            item_move;
    logic                            in_take;

    tmps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tmps_shade u_shade (
        .cfg        (cfg),
        .item       (item_reg),
        .track      (track_reg),
        .color      (color_next),
        .track_next (track_next)
    );

    assign out_free    = !out_valid_reg || shade.ready;
    assign item_move   = item_valid_reg && out_free;
    assign pixel.ready = !item_valid_reg || out_free;
    assign in_take     = pixel.valid && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            track_reg.light <= tmps_pkg::LIGHT_RESET;
            track_reg.col   <= '0;
            track_reg.row   <= '0;
        end
        else
        begin
            if (pixel.ready)
                item_valid_reg <= pixel.valid;
            if (out_free)
                out_valid_reg <= item_valid_reg;
            if (item_move)
                track_reg <= track_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.normal_x    <= pixel.normal_x;
            item_reg.normal_y    <= pixel.normal_y;
            item_reg.normal_z    <= pixel.normal_z;
            item_reg.land_kind   <= pixel.land_kind;
            item_reg.is_edge     <= pixel.is_edge;
            item_reg.pixel_col   <= pixel.pixel_col;
            item_reg.pixel_row   <= pixel.pixel_row;
            item_reg.frame_start <= pixel.frame_start;
        end
        if (item_move)
        begin
            color_reg <= color_next;
            bcol_reg  <= track_next.col;
            brow_reg  <= track_next.row;
        end
    end

    assign shade.valid         = out_valid_reg;
    assign shade.pixel_color   = color_reg;
    assign shade.brightest_col = bcol_reg;
    assign shade.brightest_row = brow_reg;

endmodule

[sim/terminator_map_pixel_shader_tb.sv]
// ----------------------------------------------------------------------------
// terminator_map_pixel_shader_tb
// Drives map pixel items through the shader and checks every shaded item against
// a directed row's result or a cycle-free predictor of the lighting, day/night
// dither, edge override and brightest-pixel tracking. The directed table covers
// extremes, band borders, saturation and frame restarts; random items follow
// under random sun and palette settings with varying sender and receiver pacing.
// ----------------------------------------------------------------------------
module terminator_map_pixel_shader_tb;
    import tmps_pkg::*;

    localparam int LATENCY       = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PER_MODE = 110;
    localparam int HOLD_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 50;
    localparam int MAX_REPORTS   = 10;

    localparam logic [PAL_W-1:0] PAL_DIR = 48'h55_44_33_22_11_0A;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } shade_t;

    typedef enum int {KEEP, CFG_BASE, CFG_BAND, CFG_NEG_SAT, CFG_POS_SAT} setup_t;

    typedef struct {
        setup_t setup;
        item_t  pix;
        bit     typed;
        shade_t want;
    } pix_row_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PAL_W-1:0]     cfg_data;

    tmps_in_if  pix_if ();
    tmps_out_if shd_if ();

    terminator_map_pixel_shader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_if),
        .shade     (shd_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfg_t   cur_cfg;
    track_t spot;
    shade_t shade_q [$];

    int errors        = 0;
    int sent          = 0;
    int results       = 0;
    int loads         = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;

    int send_pcts  [4] = '{0, 46, 0, 19};
    int stall_pcts [4] = '{0, 0, 46, 19};

    cfg_t setups [5] = '{
        '0,
        '{12'sd1024, 12'sd0, 12'sd0, 1'b1, 1'b1, PAL_DIR},
        '{12'sd650, 12'sd0, 12'sd0, 1'b1, 1'b0, PAL_DIR},
        '{12'sh800, 12'sh800, 12'sh800, 1'b0, 1'b0, PAL_DIR},
        '{12'sd2047, 12'sd2047, 12'sd2047, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF}
    };

    pix_row_t dir_tab [23] = '{
        '{KEEP, '{8'sd0, 8'sd0, 8'sd0, 2'd0, 1'b0, 8'd0, 7'd0, 1'b0}, 1'b1,
          '{8'h00, 8'd0, 7'd0}},
        '{KEEP, '{8'sd127, 8'sd0, 8'sd0, 2'd1, 1'b0, 8'd5, 7'd3, 1'b0}, 1'b1,
          '{8'h00, 8'd5, 7'd3}},
        '{CFG_BASE, '{8'sd0, 8'sd0, 8'sd0, 2'd0, 1'b0, 8'd200, 7'd100, 1'b1}, 1'b1,
          '{8'h0A, 8'd0, 7'd0}},
        '{KEEP, '{8'sd127, 8'sd0, 8'sd0, 2'd1, 1'b0, 8'd255, 7'd127, 1'b0}, 1'b1,
          '{8'h11, 8'd255, 7'd127}},
        '{KEEP, '{-8'sd128, 8'sd0, 8'sd0, 2'd3, 1'b0, 8'd1, 7'd1, 1'b0}, 1'b1,
          '{8'h55, 8'd255, 7'd127}},
        '{KEEP, '{-8'sd128, 8'sd0, 8'sd0, 2'd2, 1'b1, 8'd0, 7'd0, 1'b0}, 1'b1,
          '{8'h55, 8'd255, 7'd127}},
        '{KEEP, '{8'sd1, 8'sd0, 8'sd0, 2'd2, 1'b0, 8'd1, 7'd0, 1'b0}, 1'b1,
          '{8'h44, 8'd255, 7'd127}},
        '{KEEP, '{8'sd1, 8'sd0, 8'sd0, 2'd2, 1'b0, 8'd2, 7'd0, 1'b0}, 1'b1,
          '{8'h22, 8'd255, 7'd127}},
        '{KEEP, '{8'sd127, 8'sd0, 8'sd0, 2'd0, 1'b1, 8'd9, 7'd9, 1'b0}, 1'b1,
          '{8'h0A, 8'd255, 7'd127}},
        '{KEEP, '{8'sd127, 8'sd0, 8'sd0, 2'd1, 1'b0, 8'd9, 7'd9, 1'b0}, 1'b1,
          '{8'h11, 8'd255, 7'd127}},
        '{KEEP, '{-8'sd1, 8'sd127, -8'sd128, 2'd1, 1'b0, 8'd0, 7'd1, 1'b0}, 1'b0, '0},
        '{KEEP, '{8'sd0, -8'sd128, 8'sd127, 2'd3, 1'b0, 8'd3, 7'd3, 1'b0}, 1'b0, '0},
        '{CFG_BAND, '{8'sd10, 8'sd0, 8'sd0, 2'd1, 1'b0, 8'd0, 7'd1, 1'b1}, 1'b0, '0},
        '{KEEP, '{-8'sd10, 8'sd0, 8'sd0, 2'd1, 1'b0, 8'd0, 7'd1, 1'b0}, 1'b0, '0},
        '{KEEP, '{8'sd9, 8'sd0, 8'sd0, 2'd1, 1'b0, 8'd3, 7'd0, 1'b0}, 1'b0, '0},
        '{KEEP, '{-8'sd9, 8'sd0, 8'sd0, 2'd3, 1'b0, 8'd4, 7'd0, 1'b0}, 1'b0, '0},
        '{KEEP, '{-8'sd128, 8'sd0, 8'sd0, 2'd2, 1'b1, 8'd6, 7'd2, 1'b0}, 1'b0, '0},
        '{CFG_NEG_SAT, '{-8'sd128, -8'sd128, -8'sd128, 2'd1, 1'b0, 8'd10, 7'd20, 1'b1},
          1'b0, '0},
        '{KEEP, '{8'sd127, 8'sd127, 8'sd127, 2'd2, 1'b0, 8'd30, 7'd40, 1'b0}, 1'b0, '0},
        '{KEEP, '{-8'sd128, -8'sd128, -8'sd128, 2'd3, 1'b1, 8'd7, 7'd7, 1'b0}, 1'b0, '0},
        '{KEEP, '{8'sd127, 8'sd127, 8'sd127, 2'd1, 1'b0, 8'd1, 7'd2, 1'b1}, 1'b1,
          '{8'h11, 8'd0, 7'd0}},
        '{CFG_POS_SAT, '{8'sd127, 8'sd127, 8'sd127, 2'd1, 1'b1, 8'd255, 7'd127, 1'b0},
          1'b0, '0},
        '{KEEP, '{-8'sd128, -8'sd128, -8'sd128, 2'd0, 1'b1, 8'd128, 7'd64, 1'b0}, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic shade_t shade_pixel(input item_t it);
        int                   lit;
        logic                 night;
        logic [PAL_IDX_W-1:0] idx;
        shade_t               r;
        if (it.frame_start)
            spot = '{light: LIGHT_RESET, default: '0};
        r.color = cur_cfg.palette_words[COLOR_W*int'(PAL_WATER) +: COLOR_W];
        if (it.land_kind != KIND_WATER)
        begin
            lit = int'($signed(it.normal_x)) * int'($signed(cur_cfg.sun_x))
                + int'($signed(it.normal_y)) * int'($signed(cur_cfg.sun_y))
                + int'($signed(it.normal_z)) * int'($signed(cur_cfg.sun_z));
            if (lit > int'(LIGHT_MAX))
                lit = int'(LIGHT_MAX);
            if (lit < int'(LIGHT_MIN))
                lit = int'(LIGHT_MIN);
            if (lit > int'($signed(spot.light)))
                spot = '{LIGHT_W'(lit), it.pixel_col, it.pixel_row};
            night = cur_cfg.day_night_enable && (lit < 0);
            if (cur_cfg.day_night_enable && lit > int'(BAND_LOW) && lit < int'(BAND_HIGH))
                night = it.pixel_col[0] ^ it.pixel_row[0];
            idx = PAL_IDX_W'(it.land_kind) + (night ? PAL_NIGHT_OFS : PAL_WATER);
            r.color = cur_cfg.palette_words[COLOR_W*int'(idx) +: COLOR_W];
            if (cur_cfg.edge_enable && it.is_edge)
                r.color = cur_cfg.palette_words[COLOR_W*int'(PAL_EDGE) +: COLOR_W];
        end
        r.col = spot.col;
        r.row = spot.row;
        return r;
    endfunction

    function automatic logic signed [SUN_W-1:0] rand_sun();
        if ($urandom_range(3) == 0)
            return SUN_W'($urandom);
        return SUN_W'(int'($urandom_range(2048)) - 1024);
    endfunction

    function automatic cfg_t rand_config();
        cfg_t c;
        c.sun_x            = rand_sun();
        c.sun_y            = rand_sun();
        c.sun_z            = rand_sun();
        c.day_night_enable = 1'($urandom_range(1));
        c.edge_enable      = 1'($urandom_range(1));
        c.palette_words    = {16'($urandom), 32'($urandom)};
        return c;
    endfunction

    function automatic item_t rand_pixel();
        item_t it;
        // small normals keep the light low, so it often falls inside the dither band
        if ($urandom_range(2) == 0)
        begin
            it.normal_x = NORMAL_W'(int'($urandom_range(16)) - 8);
            it.normal_y = NORMAL_W'(int'($urandom_range(16)) - 8);
            it.normal_z = NORMAL_W'(int'($urandom_range(16)) - 8);
        end
        else
        begin
            it.normal_x = NORMAL_W'($urandom);
            it.normal_y = NORMAL_W'($urandom);
            it.normal_z = NORMAL_W'($urandom);
        end
        it.land_kind   = KIND_W'($urandom_range(3));
        it.is_edge     = 1'($urandom_range(1));
        it.pixel_col   = COL_W'($urandom);
        it.pixel_row   = ROW_W'($urandom);
        it.frame_start = ($urandom_range(31) == 0);
        return it;
    endfunction

    task automatic load_config(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SUN_X;
        cfg_data  <= {{(PAL_W-SUN_W){c.sun_x[SUN_W-1]}}, c.sun_x};
        @(posedge clk);
        cfg_index <= REG_SUN_Y;
        cfg_data  <= {{(PAL_W-SUN_W){c.sun_y[SUN_W-1]}}, c.sun_y};
        @(posedge clk);
        cfg_index <= REG_SUN_Z;
        cfg_data  <= {{(PAL_W-SUN_W){c.sun_z[SUN_W-1]}}, c.sun_z};
        @(posedge clk);
        cfg_index <= REG_DAY_NIGHT;
        cfg_data  <= {{(PAL_W-1){1'b0}}, c.day_night_enable};
        @(posedge clk);
        cfg_index <= REG_EDGE;
        cfg_data  <= {{(PAL_W-1){1'b0}}, c.edge_enable};
        @(posedge clk);
        cfg_index <= REG_PALETTE;
        cfg_data  <= c.palette_words;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
        loads++;
    endtask

    task automatic offer_pixel(input item_t it, input bit typed, input shade_t want);
        shade_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.normal_x    <= it.normal_x;
        pix_if.normal_y    <= it.normal_y;
        pix_if.normal_z    <= it.normal_z;
        pix_if.land_kind   <= it.land_kind;
        pix_if.is_edge     <= it.is_edge;
        pix_if.pixel_col   <= it.pixel_col;
        pix_if.pixel_row   <= it.pixel_row;
        pix_if.frame_start <= it.frame_start;
        do
            @(posedge clk);
        while (!pix_if.ready);
        pred = shade_pixel(it);
        shade_q.push_back(typed ? want : pred);
        sent++;
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic check_shade();
        shade_t want;
        shade_t got;
        got = '{shd_if.pixel_color, shd_if.brightest_col, shd_if.brightest_row};
        results++;
        if (shade_q.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("unexpected result: color %02h col %0d row %0d",
                         got.color, got.col, got.row);
        end
        else
        begin
            want = shade_q.pop_front();
            if (got.color !== want.color || got.col !== want.col || got.row !== want.row)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("item %0d: expected %02h %0d %0d, actual %02h %0d %0d",
                             results, want.color, want.col, want.row,
                             got.color, got.col, got.row);
            end
        end
    endtask

    // output side: checks each item and paces ready
    initial
    begin
        int hold_left;
        hold_left = 0;
        shd_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (shd_if.valid && shd_if.ready)
                check_shade();
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                shd_if.ready <= 1'b0;
                hold_left--;
            end
            else
                shd_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d items still awaited", cycles, shade_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        pix_if.valid       = 1'b0;
        pix_if.normal_x    = '0;
        pix_if.normal_y    = '0;
        pix_if.normal_z    = '0;
        pix_if.land_kind   = KIND_WATER;
        pix_if.is_edge     = 1'b0;
        pix_if.pixel_col   = '0;
        pix_if.pixel_row   = '0;
        pix_if.frame_start = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SUN_X;
        cfg_data  = '0;
        rst_n     = 1'b0;
        cur_cfg   = '{SUN_X_RESET, 12'sd0, 12'sd0, 1'b0, 1'b0, '0};
        spot      = '{light: LIGHT_RESET, default: '0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(dir_tab); i++)
        begin
            if (dir_tab[i].setup != KEEP)
            begin
                settle();
                load_config(setups[int'(dir_tab[i].setup)]);
            end
            offer_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int m = 0; m < 4; m++)
        begin
            settle();
            load_config(rand_config());
            send_idle_pct = send_pcts[m];
            stall_pct     = stall_pcts[m];
            repeat (RAND_PER_MODE) offer_pixel(rand_pixel(), 1'b0, '0);
        end

        // long output hold-offs with the input pushing every cycle
        settle();
        load_config(rand_config());
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int n = 0; n < HOLD_ITEMS; n++)
        begin
            if (n == 5 || n == 35)
                hold_req = HOLD_CYCLES;
            offer_pixel(rand_pixel(), 1'b0, '0);
        end

        settle();
        repeat (LATENCY * 4) @(posedge clk);
        $display("covered %0d pixel items and %0d shaded results over %0d register loads",
                 sent, results, loads);
        $display("pacing: free run, sender gaps, receiver stalls, both, and long hold-offs");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
